[sv/tsp_pkg.sv]
`default_nettype none

package tsp_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_MIN_SPEED  = 3'd0;
  localparam logic [2:0] CFG_MID_SPEED  = 3'd1;
  localparam logic [2:0] CFG_MAX_SPEED  = 3'd2;
  localparam logic [2:0] CFG_ACCEL_RATE = 3'd3;
  localparam logic [2:0] CFG_DECEL_RATE = 3'd4;

  localparam logic [7:0] MIN_SPEED_RST  = 8'd0;
  localparam logic [7:0] MID_SPEED_RST  = 8'd127;
  localparam logic [7:0] MAX_SPEED_RST  = 8'd255;
  localparam logic [7:0] ACCEL_RATE_RST = 8'd0;
  localparam logic [7:0] DECEL_RATE_RST = 8'd0;

  // Rates above this value give the same step time
  localparam logic [7:0] RATE_CAP = 8'd36;

  // Operation selected by tuser
  localparam logic FUNC_MAP  = 1'b0;
  localparam logic FUNC_RAMP = 1'b1;

  // Quotient bits resolved by one divider stage
  localparam int unsigned DIV_STEP = 4;

  typedef struct packed {
    logic [6:0]          rem;
    logic [DIV_STEP-1:0] quo;
  } tsp_div_t;

endpackage

`default_nettype wire

[sv/tsp_div_step.sv]
`default_nettype none

// Restoring division slice: shifts in four dividend bits, most significant first,
// and resolves one quotient bit for each.
module tsp_div_step (
  input  wire logic [6:0]                   divisor_i,
  input  wire logic [6:0]                   rem_i,
  input  wire logic [tsp_pkg::DIV_STEP-1:0] bits_i,
  output tsp_pkg::tsp_div_t                 res_o
);
  import tsp_pkg::*;

  always_comb begin
    logic [7:0] trial;
    logic [6:0] rem;
    rem   = rem_i;
    trial = '0;
    res_o = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      trial = {rem, bits_i[i]};
      if (trial >= {1'b0, divisor_i}) begin
        trial            = trial - {1'b0, divisor_i};
        res_o.quo[i]     = 1'b1;
      end
      rem = trial[6:0];
    end
    res_o.rem = rem;
  end

endmodule

`default_nettype wire

[sv/throttle_speed_profile_top.sv]
`default_nettype none

// Throttle curve and speed ramp. Each transaction on the slave side carries an
// operation in tuser (0 map throttle to speed, 1 ramp current speed toward goal)
// and yields exactly one speed on the master side. The datapath is a four-stage
// pipeline (operand set-up, multiply / upper quotient bits, divide by 255 /
// lower quotient bits, final add and clip into the output register): one item is
// taken every cycle unless the output stalls; a stall only backs up as far as
// the first empty stage. The configuration port is always ready and takes effect
// at once; write it only while the pipeline is empty. No clearing pass after reset.
module throttle_speed_profile_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [7:0] throttle, [15:8] current_speed, [23:16] goal_speed, [31:24] elapsed_ms
  input  wire logic [31:0] s_axis_tdata,
  // [0] func
  input  wire logic        s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] speed_out
  output      logic [7:0]  m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import tsp_pkg::*;

  // Configuration registers
  logic [7:0] min_speed_q, mid_speed_q, max_speed_q, accel_rate_q, decel_rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q  <= MIN_SPEED_RST;
      mid_speed_q  <= MID_SPEED_RST;
      max_speed_q  <= MAX_SPEED_RST;
      accel_rate_q <= ACCEL_RATE_RST;
      decel_rate_q <= DECEL_RATE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN_SPEED:  min_speed_q  <= cfg_data_i;
        CFG_MID_SPEED:  mid_speed_q  <= cfg_data_i;
        CFG_MAX_SPEED:  max_speed_q  <= cfg_data_i;
        CFG_ACCEL_RATE: accel_rate_q <= cfg_data_i;
        CFG_DECEL_RATE: decel_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor moves
  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign rdy4          = !v4_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [7:0] thr, cur, goal, dt;
  assign thr  = s_axis_tdata[7:0];
  assign cur  = s_axis_tdata[15:8];
  assign goal = s_axis_tdata[23:16];
  assign dt   = s_axis_tdata[31:24];

  logic       byp1_d, neg1_d, up1_d, long1_d;
  logic [7:0] bval1_d, from1_d, adiff1_d, frac1_d;
  logic [6:0] st1_d;

  always_comb begin
    logic [7:0] to;
    logic [7:0] rate;
    logic [7:0] capped;
    logic [7:0] st7;
    byp1_d  = 1'b0;
    bval1_d = goal;
    from1_d = min_speed_q;
    to      = max_speed_q;
    frac1_d = thr;
    up1_d   = cur < goal;
    rate    = up1_d ? accel_rate_q : decel_rate_q;
    capped  = (rate > RATE_CAP) ? RATE_CAP : rate;
    // step time = capped * 3.5, truncated
    st7     = (capped << 3) - capped;
    st1_d   = st7[7:1];
    long1_d = dt > {1'b0, st1_d};
    if (s_axis_tuser == FUNC_MAP) begin
      if (thr == 8'd0) begin
        byp1_d  = 1'b1;
        bval1_d = 8'd0;
      end else if (min_speed_q == 8'd0 || max_speed_q == 8'd0) begin
        byp1_d  = 1'b1;
        bval1_d = thr;
      end else if (mid_speed_q != 8'd0) begin
        if (!thr[7]) begin
          to      = mid_speed_q;
          frac1_d = {thr[6:0], 1'b0};
        end else begin
          from1_d = mid_speed_q;
          frac1_d = {thr[6:0], 1'b1};
        end
      end
    end else if (cur == goal || rate == 8'd0) begin
      byp1_d = 1'b1;
    end
    neg1_d   = to < from1_d;
    adiff1_d = neg1_d ? (from1_d - to) : (to - from1_d);
  end

  logic       func1_q, byp1_q, neg1_q, up1_q, long1_q;
  logic [7:0] bval1_q, from1_q, adiff1_q, frac1_q, cur1_q, goal1_q, dt1_q;
  logic [6:0] st1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      func1_q  <= s_axis_tuser;
      byp1_q   <= byp1_d;
      bval1_q  <= bval1_d;
      from1_q  <= from1_d;
      neg1_q   <= neg1_d;
      adiff1_q <= adiff1_d;
      frac1_q  <= frac1_d;
      cur1_q   <= cur;
      goal1_q  <= goal;
      dt1_q    <= dt;
      up1_q    <= up1_d;
      long1_q  <= long1_d;
      st1_q    <= st1_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  tsp_div_t div_hi;

  tsp_div_step u_div_hi (
    .divisor_i (st1_q),
    .rem_i     (7'd0),
    .bits_i    (dt1_q[7:4]),
    .res_o     (div_hi)
  );

  logic       func2_q, byp2_q, neg2_q, up2_q, long2_q;
  logic [7:0] bval2_q, from2_q, cur2_q, goal2_q;
  logic [15:0] mag2_q;
  logic [3:0] dtl2_q, qh2_q;
  logic [6:0] st2_q, rem2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      func2_q <= func1_q;
      byp2_q  <= byp1_q;
      bval2_q <= bval1_q;
      from2_q <= from1_q;
      neg2_q  <= neg1_q;
      mag2_q  <= adiff1_q * frac1_q;
      cur2_q  <= cur1_q;
      goal2_q <= goal1_q;
      up2_q   <= up1_q;
      long2_q <= long1_q;
      dtl2_q  <= dt1_q[3:0];
      st2_q   <= st1_q;
      rem2_q  <= div_hi.rem;
      qh2_q   <= div_hi.quo;
    end
  end

  // ---------------------------------------------------------------- stage 3
  tsp_div_t div_lo;

  tsp_div_step u_div_lo (
    .divisor_i (st2_q),
    .rem_i     (rem2_q),
    .bits_i    (dtl2_q),
    .res_o     (div_lo)
  );

  // Exact x / 255 for any 16-bit product of two bytes
  logic [15:0] q255_sum;
  assign q255_sum = mag2_q + {8'd0, mag2_q[15:8]} + 16'd1;

  logic       func3_q, byp3_q, neg3_q, up3_q, long3_q;
  logic [7:0] bval3_q, from3_q, qm3_q, cur3_q, goal3_q, qr3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      func3_q <= func2_q;
      byp3_q  <= byp2_q;
      bval3_q <= bval2_q;
      from3_q <= from2_q;
      neg3_q  <= neg2_q;
      qm3_q   <= q255_sum[15:8];
      cur3_q  <= cur2_q;
      goal3_q <= goal2_q;
      up3_q   <= up2_q;
      long3_q <= long2_q;
      qr3_q   <= {qh2_q, div_lo.quo};
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [7:0] speed4_d;

  always_comb begin
    logic [7:0] d;
    logic [7:0] gap;
    d   = long3_q ? qr3_q : 8'd1;
    gap = up3_q ? (goal3_q - cur3_q) : (cur3_q - goal3_q);
    if (byp3_q) begin
      speed4_d = bval3_q;
    end else if (func3_q == FUNC_MAP) begin
      speed4_d = neg3_q ? (from3_q - qm3_q) : (from3_q + qm3_q);
    end else if (gap > d) begin
      speed4_d = up3_q ? (cur3_q + d) : (cur3_q - d);
    end else begin
      // hold at the goal rather than overshoot
      speed4_d = goal3_q;
    end
  end

  logic [7:0] speed4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      speed4_q <= speed4_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = speed4_q;

  // ---------------------------------------------------------------- checks
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && func1_q == FUNC_RAMP && !byp1_q) |-> (st1_q != 7'd0))
    else $error("ramp divider entered with zero step time");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && func2_q == FUNC_RAMP && !byp2_q) |-> (rem2_q < st2_q))
    else $error("partial remainder not below divisor");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(speed4_q)))
    else $error("pending result lost or changed under stall");

endmodule

`default_nettype wire

[tb/tb_throttle_speed_profile_top.sv]
`default_nettype none

module tb_throttle_speed_profile_top;
  import tsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 83;

  class speed_scoreboard;
    localparam int MAP_SPAN   = 255;
    localparam int SEG_TOP    = 127;
    localparam int SEG_BASE   = 128;
    localparam int STEP_SCALE = 896;
    localparam int STEP_DIV   = 256;

    logic [7:0] min_spd, mid_spd, max_spd, acc_rate, dec_rate;
    logic [7:0] expected_speeds[$];
    int errors, checked, maps, ramps;

    function new();
      min_spd  = MIN_SPEED_RST;
      mid_spd  = MID_SPEED_RST;
      max_spd  = MAX_SPEED_RST;
      acc_rate = ACCEL_RATE_RST;
      dec_rate = DECEL_RATE_RST;
      errors   = 0;
      checked  = 0;
      maps     = 0;
      ramps    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        CFG_MIN_SPEED:  min_spd  = val;
        CFG_MID_SPEED:  mid_spd  = val;
        CFG_MAX_SPEED:  max_spd  = val;
        CFG_ACCEL_RATE: acc_rate = val;
        CFG_DECEL_RATE: dec_rate = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_speeds.size();
    endfunction

    // Signed division truncates toward zero, so a falling curve rounds upward
    function logic [7:0] interp(int from, int to, int f);
      int part;
      part = ((to - from) * f) / MAP_SPAN;
      return 8'(from + part);
    endfunction

    function logic [7:0] map_throttle(logic [7:0] thr);
      int t;
      t = thr;
      if (t == 0) return 8'd0;
      if (min_spd == 0 || max_spd == 0) return thr;
      if (mid_spd == 0) return interp(min_spd, max_spd, t);
      if (t <= SEG_TOP) return interp(min_spd, mid_spd, 2 * t);
      return interp(mid_spd, max_spd, 2 * (t - SEG_BASE) + 1);
    endfunction

    function int step_ms(logic [7:0] rate);
      int r;
      r = rate;
      if (r > RATE_CAP) r = RATE_CAP;
      return r * STEP_SCALE / STEP_DIV;
    endfunction

    function int speed_change(logic [7:0] rate, logic [7:0] dt);
      int st, d;
      st = step_ms(rate);
      d  = dt;
      if (st != 0 && d > st) return d / st;
      return 1;
    endfunction

    function logic [7:0] ramp_toward(logic [7:0] cur, logic [7:0] goal, logic [7:0] dt);
      int c, g, d;
      c = cur;
      g = goal;
      if (c < g && acc_rate != 0) begin
        d = speed_change(acc_rate, dt);
        return (g - c > d) ? 8'(c + d) : goal;
      end
      if (c > g && dec_rate != 0) begin
        d = speed_change(dec_rate, dt);
        return (c - g > d) ? 8'(c - d) : goal;
      end
      return goal;
    endfunction

    function void note_command(logic func, logic [7:0] thr, logic [7:0] cur,
                               logic [7:0] goal, logic [7:0] dt);
      if (func == FUNC_MAP) begin
        expected_speeds.push_back(map_throttle(thr));
        maps++;
      end else begin
        expected_speeds.push_back(ramp_toward(cur, goal, dt));
        ramps++;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_speed(logic [7:0] got);
      logic [7:0] want;
      if (expected_speeds.size() == 0) begin
        report($sformatf("speed %0d delivered with nothing outstanding", got));
      end else begin
        want = expected_speeds.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("speed_out %0d, expected %0d (result %0d)", got, want, checked));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = FUNC_MAP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_MIN_SPEED;
  logic [7:0]  cfg_data_i = '0;

  speed_scoreboard sb = new();
  bit no_idle   = 1'b0;
  bit long_hold = 1'b0;
  int reg_writes = 0;
  int idle_cycles = 0;

  throttle_speed_profile_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function int draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // Favour end points and the rate cap when picking a register value
  function logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return RATE_CAP;
      4: return RATE_CAP + 8'd1;
      default: return rnd8();
    endcase
  endfunction

  // Called at a falling edge; leaves tvalid high so the next command can follow at once
  task send_command(logic func, logic [7:0] thr, logic [7:0] cur,
                    logic [7:0] goal, logic [7:0] dt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = func;
    s_axis_tdata  = {dt, goal, cur, thr};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(func, thr, cur, goal, dt);
    @(negedge clk_i);
  endtask

  task write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    reg_writes++;
    @(negedge clk_i);
  endtask

  task load_profile(logic [7:0] mn, logic [7:0] md, logic [7:0] mx,
                    logic [7:0] acc, logic [7:0] dec);
    write_reg(CFG_MIN_SPEED, mn);
    write_reg(CFG_MID_SPEED, md);
    write_reg(CFG_MAX_SPEED, mx);
    write_reg(CFG_ACCEL_RATE, acc);
    write_reg(CFG_DECEL_RATE, dec);
    cfg_valid_i = 1'b0;
  endtask

  // Hold the input and wait for the pipeline to empty
  task wait_for_speeds();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task random_command();
    logic [7:0] thr, cur, goal, dt;
    case ($urandom_range(0, 5))
      0: thr = 8'd0;
      1: thr = 8'd255;
      2: thr = 8'd127 + 8'($urandom_range(0, 1));
      default: thr = rnd8();
    endcase
    cur = rnd8();
    case ($urandom_range(0, 3))
      0: goal = cur;
      1: goal = cur + 8'($urandom_range(0, 8)) - 8'd4;
      default: goal = rnd8();
    endcase
    case ($urandom_range(0, 4))
      0: dt = 8'd0;
      1: dt = 8'd255;
      2: dt = 8'($urandom_range(0, 8));
      default: dt = rnd8();
    endcase
    send_command($urandom_range(0, 1) ? FUNC_RAMP : FUNC_MAP, thr, cur, goal, dt);
  endtask

  // Result side
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_speed(m_axis_tdata);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("throttle_speed_profile_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset profile: curve disabled by zero minimum, rates jump straight to goal
    send_command(FUNC_MAP, 8'd0, rnd8(), rnd8(), rnd8());
    send_command(FUNC_MAP, 8'd1, rnd8(), rnd8(), rnd8());
    send_command(FUNC_MAP, 8'd128, rnd8(), rnd8(), rnd8());
    send_command(FUNC_MAP, 8'd255, rnd8(), rnd8(), rnd8());
    send_command(FUNC_RAMP, rnd8(), 8'd10, 8'd200, 8'd5);
    send_command(FUNC_RAMP, rnd8(), 8'd200, 8'd10, 8'd0);
    wait_for_speeds();

    // Single segment
    load_profile(8'd10, 8'd0, 8'd200, 8'd0, 8'd0);
    send_command(FUNC_MAP, 8'd1, rnd8(), rnd8(), rnd8());
    send_command(FUNC_MAP, 8'd100, rnd8(), rnd8(), rnd8());
    send_command(FUNC_MAP, 8'd255, rnd8(), rnd8(), rnd8());
    wait_for_speeds();

    // Two segments either side of the split
    load_profile(8'd10, 8'd100, 8'd200, 8'd0, 8'd0);
    send_command(FUNC_MAP, 8'd127, rnd8(), rnd8(), rnd8());
    send_command(FUNC_MAP, 8'd128, rnd8(), rnd8(), rnd8());
    send_command(FUNC_MAP, 8'd255, rnd8(), rnd8(), rnd8());
    wait_for_speeds();

    // Falling curve, capped rate, long and short intervals, clip at goal
    load_profile(8'd255, 8'd128, 8'd1, RATE_CAP, 8'd255);
    send_command(FUNC_MAP, 8'd64, rnd8(), rnd8(), rnd8());
    send_command(FUNC_MAP, 8'd200, rnd8(), rnd8(), rnd8());
    send_command(FUNC_RAMP, rnd8(), 8'd50, 8'd50, 8'd9);
    send_command(FUNC_RAMP, rnd8(), 8'd10, 8'd20, 8'd126);
    send_command(FUNC_RAMP, rnd8(), 8'd0, 8'd255, 8'd255);
    send_command(FUNC_RAMP, rnd8(), 8'd100, 8'd101, 8'd255);
    send_command(FUNC_RAMP, rnd8(), 8'd255, 8'd0, 8'd200);
    wait_for_speeds();

    // Shortest step time
    load_profile(8'd1, 8'd255, 8'd255, 8'd1, 8'd1);
    send_command(FUNC_RAMP, rnd8(), 8'd0, 8'd255, 8'd255);
    send_command(FUNC_RAMP, rnd8(), 8'd255, 8'd0, 8'd255);
    send_command(FUNC_RAMP, rnd8(), 8'd5, 8'd0, 8'd255);
    wait_for_speeds();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_profile(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        1: load_profile(8'd1, 8'd0, 8'd255, 8'd1, 8'd1);
        default: load_profile(pick_level(), pick_level(), pick_level(),
                              pick_level(), pick_level());
      endcase
      no_idle = (phase == 2 || phase == 7);
      // Back up the pipeline while commands keep coming
      if (phase == 3) long_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_command();
        if (phase == 5 && i == PHASE_ITEMS / 2) wait_for_speeds();
      end
      wait_for_speeds();
    end

    $display("run covered %0d map and %0d ramp commands, %0d speeds checked,",
             sb.maps, sb.ramps, sb.checked);
    $display("%0d register writes over %0d profiles, mismatches %0d",
             reg_writes, PHASES + 4, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("throttle_speed_profile_top verification clean");
    else
      $display("throttle_speed_profile_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/tsp_pkg.sv
sv/tsp_div_step.sv
sv/throttle_speed_profile_top.sv
tb/tb_throttle_speed_profile_top.sv
